// ===== design/thick_line_raster_macros.svh =====
// Assertion macros shared by the thick line raster design.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef THICK_LINE_RASTER_MACROS_SVH
`define THICK_LINE_RASTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thick_line_raster: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thick_line_raster: next-cycle check failed");

`endif

// ===== design/tlr_pkg.sv =====
// Package for the thick line raster: command codes, register indexes and shared types.
// Depends on nothing; used by the interfaces, the walker and the top level.
`default_nettype none

package tlr_pkg;

    localparam int COLOR_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 30;
    localparam int BASE_W      = 30;
    localparam int PITCH_W     = 16;
    localparam int SCREEN_W    = 13;
    localparam int ADDR_W      = 32;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_FRAME_BASE    = 2'd0,
        CFG_LINE_PITCH    = 2'd1,
        CFG_SCREEN_WIDTH  = 2'd2,
        CFG_SCREEN_HEIGHT = 2'd3
    } cfg_reg_t;

    localparam logic [BASE_W-1:0]   FRAME_BASE_RST    = 30'd0;
    localparam logic [PITCH_W-1:0]  LINE_PITCH_RST    = 16'd4096;
    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

    typedef struct packed
    {
        logic valid;
        logic off;
        logic last;
    } pix_flags_t;

endpackage

`default_nettype wire

// ===== design/tlr_cmd_if.sv =====
// Command channel of the thick line raster: valid/ready handshake with line fields.
// Depends on tlr_pkg for the colour width.
`default_nettype none

interface tlr_cmd_if
    import tlr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int THICK_BITS = 6
);
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [COORD_BITS-1:0]  x_start;
    logic [COORD_BITS-1:0]  y_start;
    logic [COORD_BITS-1:0]  x_end;
    logic [COORD_BITS-1:0]  y_end;
    logic [COLOR_W-1:0]     color;
    logic [THICK_BITS-1:0]  thickness;

    modport source (output valid, opcode, x_start, y_start, x_end, y_end, color, thickness,
                    input ready);
    modport sink (input valid, opcode, x_start, y_start, x_end, y_end, color, thickness,
                  output ready);
endinterface

`default_nettype wire

// ===== design/tlr_pix_if.sv =====
// Pixel channel of the thick line raster: valid/ready handshake with one pixel per transfer.
// Depends on tlr_pkg for the colour and address widths.
`default_nettype none

interface tlr_pix_if
    import tlr_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS:0]   pixel_x;
    logic signed [COORD_BITS:0]   pixel_y;
    logic [COLOR_W-1:0]           pixel_color;
    logic [ADDR_W-1:0]            byte_address;
    logic                         off_screen;
    logic                         last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, byte_address, off_screen,
                    last_pixel, input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_color, byte_address, off_screen,
                  last_pixel, output ready);
endinterface

`default_nettype wire

// ===== design/tlr_walk.sv =====
// Line walker: holds the line state and advances the error walk by one pixel per step.
// Depends on tlr_pkg for the command codes and the pixel flag struct.
`default_nettype none

module tlr_walk
    import tlr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int THICK_BITS = 6
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         take,
    input  wire logic                         opcode,
    input  wire logic [COORD_BITS-1:0]        x_start,
    input  wire logic [COORD_BITS-1:0]        y_start,
    input  wire logic [COORD_BITS-1:0]        x_end,
    input  wire logic [COORD_BITS-1:0]        y_end,
    input  wire logic [COLOR_W-1:0]           color,
    input  wire logic [THICK_BITS-1:0]        thickness,
    input  wire logic [SCREEN_W-1:0]          screen_width,
    input  wire logic [SCREEN_W-1:0]          screen_height,
    output logic signed [COORD_BITS:0]        pix_x,
    output logic signed [COORD_BITS:0]        pix_y,
    output logic [COLOR_W-1:0]                pix_color,
    output pix_flags_t                        flags,
    output logic                              busy
);

    localparam int PW    = COORD_BITS + 1;
    localparam int EW    = COORD_BITS + 2;
    localparam int CMP_W = (PW > SCREEN_W) ? PW : SCREEN_W;

    logic                    busy_reg, busy_next;
    logic signed [PW-1:0]    cursor_x_reg, cursor_x_next;
    logic signed [PW-1:0]    cursor_y_reg, cursor_y_next;
    logic signed [PW-1:0]    target_x_reg, target_x_next;
    logic signed [PW-1:0]    target_y_reg, target_y_next;
    logic [COORD_BITS-1:0]   x1_reg, x1_next;
    logic [COORD_BITS-1:0]   y1_reg, y1_next;
    logic [COORD_BITS-1:0]   x2_reg, x2_next;
    logic [COORD_BITS-1:0]   y2_reg, y2_next;
    logic [COORD_BITS-1:0]   delta_x_reg, delta_x_next;
    logic [COORD_BITS-1:0]   delta_y_reg, delta_y_next;
    logic [1:0]              step_signs_reg, step_signs_next;
    logic                    major_is_x_reg, major_is_x_next;
    logic signed [EW-1:0]    error_reg, error_next;
    logic [THICK_BITS-1:0]   pass_index_reg, pass_index_next;
    logic [THICK_BITS-1:0]   pass_count_reg, pass_count_next;
    logic [COLOR_W-1:0]      color_reg, color_next;

    logic                    at_end;
    logic                    final_pass;
    logic                    is_step;
    logic signed [EW:0]      e2;
    logic signed [EW:0]      dx_ext;
    logic signed [EW:0]      dy_ext;
    logic                    move_x;
    logic                    move_y;
    logic [THICK_BITS-1:0]   pass_inc;
    logic [COORD_BITS-1:0]   in_dx;
    logic [COORD_BITS-1:0]   in_dy;

    assign is_step    = (opcode == OP_STEP);
    assign at_end     = (cursor_x_reg == target_x_reg) && (cursor_y_reg == target_y_reg);
    assign final_pass = ((THICK_BITS + 1)'(pass_index_reg) + 1'b1)
                        >= (THICK_BITS + 1)'(pass_count_reg);
    assign pass_inc   = pass_index_reg + 1'b1;
    assign e2         = {error_reg, 1'b0};
    assign dx_ext     = signed'((EW + 1)'(delta_x_reg));
    assign dy_ext     = signed'((EW + 1)'(delta_y_reg));
    assign move_x     = e2 > -dy_ext;
    assign move_y     = e2 < dx_ext;
    assign in_dx      = (x_end > x_start) ? x_end - x_start : x_start - x_end;
    assign in_dy      = (y_end > y_start) ? y_end - y_start : y_start - y_end;

    assign pix_x       = cursor_x_reg;
    assign pix_y       = cursor_y_reg;
    assign pix_color   = color_reg;
    assign busy        = busy_reg;
    assign flags.valid = take && is_step && busy_reg;
    assign flags.off   = cursor_x_reg[PW-1] || cursor_y_reg[PW-1]
                         || (CMP_W'($unsigned(cursor_x_reg)) >= CMP_W'(screen_width))
                         || (CMP_W'($unsigned(cursor_y_reg)) >= CMP_W'(screen_height));
    assign flags.last  = at_end && final_pass;

    always_comb
    begin
        busy_next       = busy_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        x1_next         = x1_reg;
        y1_next         = y1_reg;
        x2_next         = x2_reg;
        y2_next         = y2_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        step_signs_next = step_signs_reg;
        major_is_x_next = major_is_x_reg;
        error_next      = error_reg;
        pass_index_next = pass_index_reg;
        pass_count_next = pass_count_reg;
        color_next      = color_reg;

        if (take && !is_step)
        begin
            x1_next         = x_start;
            y1_next         = y_start;
            x2_next         = x_end;
            y2_next         = y_end;
            delta_x_next    = in_dx;
            delta_y_next    = in_dy;
            step_signs_next = {y_start < y_end, x_start < x_end};
            major_is_x_next = in_dx > in_dy;
            color_next      = color;
            pass_count_next = thickness;
            pass_index_next = '0;
            busy_next       = (thickness != '0);
            cursor_x_next   = signed'(PW'(x_start));
            cursor_y_next   = signed'(PW'(y_start));
            target_x_next   = signed'(PW'(x_end));
            target_y_next   = signed'(PW'(y_end));
            error_next      = signed'(EW'(in_dx)) - signed'(EW'(in_dy));
        end
        else if (flags.valid)
        begin
            if (at_end)
            begin
                if (final_pass)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    pass_index_next = pass_inc;
                    cursor_x_next   = signed'(PW'(x1_reg));
                    cursor_y_next   = signed'(PW'(y1_reg));
                    target_x_next   = signed'(PW'(x2_reg));
                    target_y_next   = signed'(PW'(y2_reg));
                    if (major_is_x_reg)
                    begin
                        cursor_y_next = signed'(PW'(y1_reg)) - signed'(PW'(pass_inc));
                        target_y_next = signed'(PW'(y2_reg)) - signed'(PW'(pass_inc));
                    end
                    else
                    begin
                        cursor_x_next = signed'(PW'(x1_reg)) - signed'(PW'(pass_inc));
                        target_x_next = signed'(PW'(x2_reg)) - signed'(PW'(pass_inc));
                    end
                    error_next = signed'(EW'(delta_x_reg)) - signed'(EW'(delta_y_reg));
                end
            end
            else
            begin
                if (move_x)
                begin
                    cursor_x_next = step_signs_reg[0] ? cursor_x_reg + signed'(PW'(1))
                                                      : cursor_x_reg - signed'(PW'(1));
                end
                if (move_y)
                begin
                    cursor_y_next = step_signs_reg[1] ? cursor_y_reg + signed'(PW'(1))
                                                      : cursor_y_reg - signed'(PW'(1));
                end
                error_next = error_reg
                             - (move_x ? signed'(EW'(delta_y_reg)) : EW'(0))
                             + (move_y ? signed'(EW'(delta_x_reg)) : EW'(0));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            x1_reg         <= '0;
            y1_reg         <= '0;
            x2_reg         <= '0;
            y2_reg         <= '0;
            delta_x_reg    <= '0;
            delta_y_reg    <= '0;
            step_signs_reg <= '0;
            major_is_x_reg <= 1'b0;
            error_reg      <= '0;
            pass_index_reg <= '0;
            pass_count_reg <= '0;
            color_reg      <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            target_x_reg   <= target_x_next;
            target_y_reg   <= target_y_next;
            x1_reg         <= x1_next;
            y1_reg         <= y1_next;
            x2_reg         <= x2_next;
            y2_reg         <= y2_next;
            delta_x_reg    <= delta_x_next;
            delta_y_reg    <= delta_y_next;
            step_signs_reg <= step_signs_next;
            major_is_x_reg <= major_is_x_next;
            error_reg      <= error_next;
            pass_index_reg <= pass_index_next;
            pass_count_reg <= pass_count_next;
            color_reg      <= color_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/thick_line_raster.sv =====
// Thick line raster top level: configuration registers, pixel register and address stage.
// Depends on tlr_pkg, tlr_cmd_if, tlr_pix_if, tlr_walk and thick_line_raster_macros.svh.
// A step's pixel is held in the pixel register, then in the address stage's output register.
// Throughput: one command transfer per cycle unless pix.ready stalls; the walker advances once per step.
// The address stage holds one multiply and the adds for base and column.
// Reset clears the line state and all valid flags; configuration registers return to their defaults.
`default_nettype none
`include "thick_line_raster_macros.svh"

module thick_line_raster
    import tlr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int THICK_BITS = 6
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    tlr_cmd_if.sink                      cmd,
    tlr_pix_if.source                    pix,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int PW = COORD_BITS + 1;

    logic [BASE_W-1:0]       frame_base_reg;
    logic [PITCH_W-1:0]      line_pitch_reg;
    logic [SCREEN_W-1:0]     screen_width_reg;
    logic [SCREEN_W-1:0]     screen_height_reg;

    logic                    s1_valid_reg, s1_valid_next;
    logic signed [PW-1:0]    s1_x_reg;
    logic signed [PW-1:0]    s1_y_reg;
    logic [COLOR_W-1:0]      s1_color_reg;
    logic                    s1_off_reg;
    logic                    s1_last_reg;

    logic                    out_valid_reg, out_valid_next;
    logic signed [PW-1:0]    out_x_reg;
    logic signed [PW-1:0]    out_y_reg;
    logic [COLOR_W-1:0]      out_color_reg;
    logic [ADDR_W-1:0]       out_addr_reg;
    logic                    out_off_reg;
    logic                    out_last_reg;

    logic                    accept;
    logic                    s2_load;
    logic                    busy;
    pix_flags_t              flags;
    logic signed [PW-1:0]    walk_x;
    logic signed [PW-1:0]    walk_y;
    logic [COLOR_W-1:0]      walk_color;
    logic [COORD_BITS+PITCH_W-1:0] row_offset;
    logic [ADDR_W-1:0]       pixel_addr;

    assign s2_load   = s1_valid_reg && (!out_valid_reg || pix.ready);
    assign cmd.ready = !s1_valid_reg || s2_load;
    assign accept    = cmd.valid && cmd.ready;

    tlr_walk #(
        .COORD_BITS (COORD_BITS),
        .THICK_BITS (THICK_BITS)
    ) u_walk (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (accept),
        .opcode        (cmd.opcode),
        .x_start       (cmd.x_start),
        .y_start       (cmd.y_start),
        .x_end         (cmd.x_end),
        .y_end         (cmd.y_end),
        .color         (cmd.color),
        .thickness     (cmd.thickness),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .pix_x         (walk_x),
        .pix_y         (walk_y),
        .pix_color     (walk_color),
        .flags         (flags),
        .busy          (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg    <= FRAME_BASE_RST;
            line_pitch_reg    <= LINE_PITCH_RST;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FRAME_BASE:    frame_base_reg    <= cfg_data[BASE_W-1:0];
                CFG_LINE_PITCH:    line_pitch_reg    <= cfg_data[PITCH_W-1:0];
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SCREEN_W-1:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SCREEN_W-1:0];
                default:           frame_base_reg    <= frame_base_reg;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = flags.valid;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s2_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && flags.valid)
        begin
            s1_x_reg     <= walk_x;
            s1_y_reg     <= walk_y;
            s1_color_reg <= walk_color;
            s1_off_reg   <= flags.off;
            s1_last_reg  <= flags.last;
        end
    end

    assign row_offset = s1_y_reg[COORD_BITS-1:0] * line_pitch_reg;
    assign pixel_addr = s1_off_reg ? '0
                        : ADDR_W'(frame_base_reg) + ADDR_W'(row_offset)
                          + ADDR_W'({s1_x_reg[COORD_BITS-1:0], 2'b00});

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            out_x_reg     <= s1_x_reg;
            out_y_reg     <= s1_y_reg;
            out_color_reg <= s1_color_reg;
            out_addr_reg  <= pixel_addr;
            out_off_reg   <= s1_off_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign pix.valid        = out_valid_reg;
    assign pix.pixel_x      = out_x_reg;
    assign pix.pixel_y      = out_y_reg;
    assign pix.pixel_color  = out_color_reg;
    assign pix.byte_address = out_addr_reg;
    assign pix.off_screen   = out_off_reg;
    assign pix.last_pixel   = out_last_reg;

    `TLR_ASSERT_SAME(a_off_addr_zero, pix.valid && pix.off_screen, pix.byte_address == '0)
    `TLR_ASSERT_NEXT(a_last_idles, accept && flags.valid && flags.last, !busy)
    `TLR_ASSERT_SAME(a_ready_when_free, !s1_valid_reg, cmd.ready)

endmodule

`default_nettype wire
